// ----- hdl/awu_pkg.sv -----
package awu_pkg;

    // Field and datapath widths
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 12;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 48;
    localparam int QUO_W      = ACC_W + 1;
    localparam int ROOT_W     = (QUO_W + 1) / 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Saturation limits of a signed 32-bit word
    localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    // Register reset values
    localparam logic [PDATA_W-1:0] LR_RESET     = 32'd13107;
    localparam logic [PDATA_W-1:0] LAMBDA_RESET = 32'd0;

    // Register select, taken from paddr[2]
    typedef enum logic
    {
        REG_LEARNING_RATE = 1'b0,
        REG_LAMBDA        = 1'b1
    } reg_sel_t;

    // Request to the shared divide / square root unit
    typedef struct packed
    {
        logic             start;
        logic [ACC_W-1:0] divisor;
    } ds_req_t;

    // Response from the shared divide / square root unit
    typedef struct packed
    {
        logic              done;
        logic [ROOT_W-1:0] root;
    } ds_rsp_t;

endpackage

// ----- hdl/awu_req_if.sv -----
interface awu_req_if;

    logic                                valid;
    logic                                ready;
    logic        [awu_pkg::IDX_W-1:0]    index;
    logic signed [awu_pkg::DATA_W-1:0]   gradient;
    logic signed [awu_pkg::DATA_W-1:0]   weight_in;

    modport source
    (
        output valid,
        input  ready,
        output index,
        output gradient,
        output weight_in
    );

    modport sink
    (
        input  valid,
        output ready,
        input  index,
        input  gradient,
        input  weight_in
    );

endinterface

// ----- hdl/awu_rsp_if.sv -----
interface awu_rsp_if;

    logic                                valid;
    logic                                ready;
    logic signed [awu_pkg::DATA_W-1:0]   weight_out;

    modport source
    (
        output valid,
        input  ready,
        output weight_out
    );

    modport sink
    (
        input  valid,
        output ready,
        input  weight_out
    );

endinterface

// ----- hdl/awu_ram.sv -----
module awu_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/awu_rsqrt.sv -----
module awu_rsqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  awu_pkg::ds_req_t req,
    output awu_pkg::ds_rsp_t rsp
);

    typedef enum logic [3:0]
    {
        DS_IDLE = 4'b0001,
        DS_DIV  = 4'b0010,
        DS_SQRT = 4'b0100,
        DS_DONE = 4'b1000
    } ds_state_t;

    ds_state_t                        state_reg, state_next;
    logic [awu_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [awu_pkg::ACC_W-1:0]        den_reg, den_next;
    logic [awu_pkg::QUO_W-1:0]        rem_reg, rem_next;
    logic [awu_pkg::QUO_W:0]          quo_reg, quo_next;
    logic [awu_pkg::ROOT_W-1:0]       root_reg, root_next;

    logic                             lead_bit;
    logic [awu_pkg::QUO_W-1:0]        trial_a;
    logic [awu_pkg::QUO_W-1:0]        trial_b;
    logic [awu_pkg::QUO_W:0]          diff;
    logic                             fits;
    logic [awu_pkg::QUO_W-1:0]        new_rem;

    // Shared compare-subtract: divisor in the divide phase, 4*root+1 in the root phase
    always_comb
    begin
        lead_bit = (cnt_reg == '0);
        if (state_reg == DS_DIV)
        begin
            trial_a = {rem_reg[awu_pkg::ACC_W-1:0], lead_bit};
            trial_b = {1'b0, den_reg};
        end
        else
        begin
            trial_a = {rem_reg[awu_pkg::QUO_W-3:0],
                       quo_reg[awu_pkg::QUO_W:awu_pkg::QUO_W-1]};
            trial_b = awu_pkg::QUO_W'({root_reg, 2'b01});
        end
        diff    = {1'b0, trial_a} - {1'b0, trial_b};
        fits    = !diff[awu_pkg::QUO_W];
        new_rem = fits ? diff[awu_pkg::QUO_W-1:0] : trial_a;
    end

    // Sequence: 2^48 / divisor one quotient bit a cycle, then square root one digit a cycle
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        root_next  = root_reg;
        case (state_reg)
            DS_IDLE:
            begin
                if (req.start)
                begin
                    den_next   = req.divisor;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = DS_DIV;
                end
            end
            DS_DIV:
            begin
                quo_next = {quo_reg[awu_pkg::QUO_W-1:0], fits};
                rem_next = new_rem;
                if (cnt_reg == awu_pkg::CNT_W'(awu_pkg::DIV_STEPS - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = DS_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DS_SQRT:
            begin
                quo_next  = {quo_reg[awu_pkg::QUO_W-2:0], 2'b00};
                rem_next  = new_rem;
                root_next = {root_reg[awu_pkg::ROOT_W-2:0], fits};
                if (cnt_reg == awu_pkg::CNT_W'(awu_pkg::SQRT_STEPS - 1))
                begin
                    state_next = DS_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DS_DONE:
            begin
                state_next = DS_IDLE;
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        root_reg <= root_next;
    end

    assign rsp.done = (state_reg == DS_DONE);
    assign rsp.root = root_reg;

endmodule

// ----- hdl/adagrad_weight_update_core.sv -----
// An accepted word passes LAMBDA, GRAD, SQUARE, ACCUM, ROOT, SCALE, RATE and RESULT;
// a zero accumulator skips from ACCUM to RESULT. Only idle takes a new word, after
// the last result entered the output register. The shared divide / square root unit
// runs 49 quotient then 25 root steps, one per cycle. Reset: asynchronous, active
// low; control/config registers reset, then all accumulators are zeroed, ready low.
module adagrad_weight_update_core #(
    parameter int PARAM_COUNT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    awu_req_if.sink                       req,
    awu_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [awu_pkg::PADDR_W-1:0]   paddr,
    input  logic [awu_pkg::PDATA_W-1:0]   pwdata,
    output logic [awu_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

    typedef enum logic [9:0]
    {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_LAMBDA = 10'b00_0000_0100,
        ST_GRAD   = 10'b00_0000_1000,
        ST_SQUARE = 10'b00_0001_0000,
        ST_ACCUM  = 10'b00_0010_0000,
        ST_ROOT   = 10'b00_0100_0000,
        ST_SCALE  = 10'b00_1000_0000,
        ST_RATE   = 10'b01_0000_0000,
        ST_RESULT = 10'b10_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [awu_pkg::PDATA_W-1:0]     lr_reg;
    logic [awu_pkg::PDATA_W-1:0]     lambda_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [awu_pkg::DATA_W-1:0]      out_data_reg, out_data_next;

    logic [AW-1:0]                   addr_reg, addr_next;
    logic                            in_range_reg, in_range_next;
    logic [awu_pkg::DATA_W-1:0]      grad_reg, grad_next;
    logic [awu_pkg::DATA_W-1:0]      w_reg, w_next;
    logic                            g_neg_reg, g_neg_next;
    logic [awu_pkg::DATA_W-1:0]      gmag_reg, gmag_next;
    logic                            zero_reg, zero_next;
    logic [2*awu_pkg::DATA_W-1:0]    prod_reg, prod_next;

    logic                            accept;
    logic                            cfg_write;
    awu_pkg::reg_sel_t               reg_sel;

    logic [awu_pkg::DATA_W-1:0]      mul_a;
    logic [awu_pkg::DATA_W-1:0]      mul_b;
    logic [awu_pkg::DATA_W-1:0]      wmag;
    logic [awu_pkg::DATA_W-1:0]      tsat;

    logic signed [awu_pkg::ACC_W:0]  grad_ext;
    logic signed [awu_pkg::ACC_W:0]  pterm;
    logic signed [awu_pkg::ACC_W:0]  gsum;
    logic [awu_pkg::DATA_W-1:0]      g_sat;

    logic [awu_pkg::ACC_W-1:0]       acc_cur;
    logic [awu_pkg::ACC_W:0]         acc_sum;
    logic [awu_pkg::ACC_W-1:0]       acc_new;

    logic signed [awu_pkg::ACC_W+1:0] res_wide;
    logic [awu_pkg::DATA_W-1:0]      res_sat;
    logic                            slot_free;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [awu_pkg::ACC_W-1:0]       ram_wdata;
    logic [awu_pkg::ACC_W-1:0]       ram_rdata;

    awu_pkg::ds_req_t                ds_req;
    awu_pkg::ds_rsp_t                ds_rsp;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = awu_pkg::reg_sel_t'(paddr[2]);

    always_comb
    begin
        case (reg_sel)
            awu_pkg::REG_LEARNING_RATE: prdata = lr_reg;
            awu_pkg::REG_LAMBDA:        prdata = lambda_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg     <= awu_pkg::LR_RESET;
            lambda_reg <= awu_pkg::LAMBDA_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                awu_pkg::REG_LEARNING_RATE: lr_reg     <= pwdata;
                awu_pkg::REG_LAMBDA:        lambda_reg <= pwdata;
                default:                    lr_reg     <= lr_reg;
            endcase
        end
    end

    // Handshakes
    assign req.ready      = (state_reg == ST_IDLE);
    assign accept         = req.valid && req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.weight_out = out_data_reg;
    assign slot_free      = !out_valid_reg || rsp.ready;

    // Accumulator memory
    awu_ram #(
        .WIDTH (awu_pkg::ACC_W),
        .DEPTH (PARAM_COUNT)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (AW'(req.index)),
        .rdata (ram_rdata)
    );

    // Shared divide / square root unit
    awu_rsqrt u_rsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .rsp   (ds_rsp)
    );

    // Operand magnitudes and saturation ahead of the multiplier
    assign wmag = w_reg[awu_pkg::DATA_W-1] ? (awu_pkg::DATA_W'(0) - w_reg) : w_reg;
    assign tsat = (|prod_reg[2*awu_pkg::DATA_W-1:awu_pkg::DATA_W+awu_pkg::FRAC_W])
                ? '1
                : prod_reg[awu_pkg::DATA_W+awu_pkg::FRAC_W-1:awu_pkg::FRAC_W];

    // Select multiplier operands per step
    always_comb
    begin
        case (state_reg)
            ST_LAMBDA:
            begin
                mul_a = lambda_reg;
                mul_b = wmag;
            end
            ST_SQUARE:
            begin
                mul_a = gmag_reg;
                mul_b = gmag_reg;
            end
            ST_SCALE:
            begin
                mul_a = gmag_reg;
                mul_b = awu_pkg::DATA_W'(ds_rsp.root);
            end
            ST_RATE:
            begin
                mul_a = lr_reg;
                mul_b = tsat;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Load the product on multiply steps, hold it otherwise
    assign prod_next = (state_reg inside {ST_LAMBDA, ST_SQUARE, ST_SCALE, ST_RATE})
                     ? (2*awu_pkg::DATA_W)'(mul_a) * (2*awu_pkg::DATA_W)'(mul_b)
                     : prod_reg;

    // Regularized gradient: grad + sign(w) * trunc(lambda * |w|), saturated
    always_comb
    begin
        grad_ext = {{(awu_pkg::ACC_W + 1 - awu_pkg::DATA_W){grad_reg[awu_pkg::DATA_W-1]}},
                    grad_reg};
        pterm    = {2'b00, prod_reg[2*awu_pkg::DATA_W-2:awu_pkg::FRAC_W]};
        gsum     = w_reg[awu_pkg::DATA_W-1] ? (grad_ext - pterm) : (grad_ext + pterm);
        if (gsum[awu_pkg::ACC_W:awu_pkg::DATA_W-1] == '0
            || gsum[awu_pkg::ACC_W:awu_pkg::DATA_W-1] == '1)
        begin
            g_sat = gsum[awu_pkg::DATA_W-1:0];
        end
        else
        begin
            g_sat = gsum[awu_pkg::ACC_W] ? awu_pkg::S32_MIN : awu_pkg::S32_MAX;
        end
    end

    // Accumulate g squared with saturation
    always_comb
    begin
        acc_cur = in_range_reg ? ram_rdata : '0;
        acc_sum = {1'b0, acc_cur} + {1'b0, prod_reg[2*awu_pkg::DATA_W-1:awu_pkg::FRAC_W]};
        acc_new = acc_sum[awu_pkg::ACC_W] ? '1 : acc_sum[awu_pkg::ACC_W-1:0];
    end

    // Apply the step against the sign of g, saturated
    always_comb
    begin
        if (g_neg_reg)
        begin
            res_wide = {{(awu_pkg::ACC_W + 2 - awu_pkg::DATA_W){w_reg[awu_pkg::DATA_W-1]}},
                        w_reg}
                     + {2'b00, prod_reg[2*awu_pkg::DATA_W-1:awu_pkg::FRAC_W]};
        end
        else
        begin
            res_wide = {{(awu_pkg::ACC_W + 2 - awu_pkg::DATA_W){w_reg[awu_pkg::DATA_W-1]}},
                        w_reg}
                     - {2'b00, prod_reg[2*awu_pkg::DATA_W-1:awu_pkg::FRAC_W]};
        end
        if (zero_reg)
        begin
            res_sat = w_reg;
        end
        else if (res_wide[awu_pkg::ACC_W+1:awu_pkg::DATA_W-1] == '0
                 || res_wide[awu_pkg::ACC_W+1:awu_pkg::DATA_W-1] == '1)
        begin
            res_sat = res_wide[awu_pkg::DATA_W-1:0];
        end
        else
        begin
            res_sat = res_wide[awu_pkg::ACC_W+1] ? awu_pkg::S32_MIN : awu_pkg::S32_MAX;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        addr_next      = addr_reg;
        in_range_next  = in_range_reg;
        grad_next      = grad_reg;
        w_next         = w_reg;
        g_neg_next     = g_neg_reg;
        gmag_next      = gmag_reg;
        zero_next      = zero_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = acc_new;
        ds_req.start   = 1'b0;
        ds_req.divisor = acc_new;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(PARAM_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next     = AW'(req.index);
                    in_range_next = (32'(req.index) < 32'(PARAM_COUNT));
                    grad_next     = req.gradient;
                    w_next        = req.weight_in;
                    state_next    = ST_LAMBDA;
                end
            end
            ST_LAMBDA:
            begin
                state_next = ST_GRAD;
            end
            ST_GRAD:
            begin
                g_neg_next = g_sat[awu_pkg::DATA_W-1];
                gmag_next  = g_sat[awu_pkg::DATA_W-1]
                           ? (awu_pkg::DATA_W'(0) - g_sat) : g_sat;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                ram_we    = in_range_reg;
                zero_next = (acc_new == '0);
                if (acc_new == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    ds_req.start = 1'b1;
                    state_next   = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (ds_rsp.done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_data_next  = res_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        addr_reg     <= addr_next;
        in_range_reg <= in_range_next;
        grad_reg     <= grad_next;
        w_reg        <= w_next;
        g_neg_reg    <= g_neg_next;
        gmag_reg     <= gmag_next;
        zero_reg     <= zero_next;
        prod_reg     <= prod_next;
    end

    // The root unit only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        ds_rsp.done |-> (state_reg == ST_ROOT))
        else $error("root unit finished outside the wait step");

    // 1/sqrt of a nonzero accumulator never exceeds 2^24
    assert property (@(posedge clk) disable iff (!rst_n)
        ds_rsp.done |-> (!ds_rsp.root[awu_pkg::ROOT_W-1]
                         || (ds_rsp.root[awu_pkg::ROOT_W-2:0] == '0)))
        else $error("inverse square root above its bound");

    // A zero accumulator implies g squared truncated to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && zero_reg)
            |-> (gmag_reg[awu_pkg::DATA_W-1:awu_pkg::FRAC_W/2] == '0))
        else $error("zero accumulator with a large gradient");

endmodule
